/* hw/rtl/ftat_pkg.sv */
// Shared types and codes for the flow accounting table.
`timescale 1ns / 1ps
package ftat_pkg;
   localparam int unsigned KEY_WIDTH = 89;

   typedef enum logic [2:0] {
      STATUS_UPDATED = 3'd0,
      STATUS_NEW     = 3'd1,
      STATUS_FULL    = 3'd2,
      STATUS_DRAINED = 3'd3,
      STATUS_EMPTY   = 3'd4
   } status_type;

   typedef struct packed {
      logic        action;
      logic [31:0] user_id;
      logic [7:0]  protocol;
      logic        direction;
      logic [31:0] source_address;
      logic [15:0] source_port;
      logic [31:0] dest_address;
      logic [15:0] dst_port;
      logic [15:0] packet_length;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] entry_user;
      logic [7:0]  entry_protocol;
      logic        entry_direction;
      logic [31:0] entry_address;
      logic [15:0] entry_port;
      logic [31:0] packet_total;
      logic [31:0] byte_total;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] user;
      logic [7:0]  protocol;
      logic        direction;
      logic [31:0] address;
      logic [15:0] port;
   } key_type;
endpackage

/* hw/rtl/ftat_if.sv */
// Valid/ready channel interfaces for request and response transfers.
`timescale 1ns / 1ps
interface ftat_req_if;
   logic valid;
   logic ready;
   ftat_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ftat_rsp_if;
   logic valid;
   logic ready;
   ftat_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/flow_traffic_accounting_table_top.sv */
// Flow accounting table top level: sequencer, key search and counter memory.
//
// One item is handled at a time. A lookup walks the table one slot per cycle
// through a registered key memory, comparing keys and tracking the
// lowest free slot; an update or a drain then reads the counter memory, and
// an update writes it back. A new entry, a full drop or an empty drain has
// its result registered in S_DONE; an update goes on through S_CRD and
// S_CWAIT, a drain through S_CRD and S_OUT (counter read). The result waits
// in an output register and the next request is taken in the cycle after it
// has been transferred. No clearing pass: valid bits in flip-flops are
// cleared by reset.
`timescale 1ns / 1ps
module flow_traffic_accounting_table_top #(
   parameter int unsigned TABLE_ENTRIES = 256
) (
   input logic clock,
   input logic reset,
   ftat_req_if.sink req_chan,
   ftat_rsp_if.source rsp_chan
);
   import ftat_pkg::*;
   localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int unsigned CW = IW + 1;

   typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DONE, S_CRD, S_CWAIT, S_OUT} state_type;

   state_type state_ff;
   req_type req_ff;
   key_type key_ff;
   logic [CW-1:0] idx_ff;     // slot being read
   logic pend_ff;             // read in flight for slot idx_ff-1
   logic [IW-1:0] hit_ff, free_ff, first_ff;
   logic hit_ok_ff, free_ok_ff, first_ok_ff, more_ff;
   logic [TABLE_ENTRIES-1:0] valid_ff;
   rsp_type rsp_ff;
   logic rsp_valid_ff;

   key_type key_mem [TABLE_ENTRIES];
   logic [63:0] cnt_mem [TABLE_ENTRIES];
   key_type key_rd_ff;
   logic [63:0] cnt_rd_ff;
   logic key_we, cnt_we;
   logic [IW-1:0] key_ra, key_wa, cnt_a;
   logic [63:0] cnt_wd;
   logic [IW-1:0] prev_idx;
   key_type req_key;

   always_comb begin
      req_key.user = req_chan.data.user_id;
      req_key.protocol = req_chan.data.protocol;
      req_key.direction = req_chan.data.direction;
      req_key.address = req_chan.data.direction ? req_chan.data.source_address
                                                : req_chan.data.dest_address;
      req_key.port = req_chan.data.direction ? req_chan.data.source_port
                                             : req_chan.data.dst_port;
   end

   assign prev_idx = IW'(idx_ff - CW'(1));
   assign key_ra = (state_ff == S_SCAN) ? idx_ff[IW-1:0] : first_ff;
   assign req_chan.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data = rsp_ff;

   always_ff @(posedge clock) begin
      if (key_we) key_mem[key_wa] <= key_ff;
      key_rd_ff <= key_mem[key_ra];
      if (cnt_we) cnt_mem[cnt_a] <= cnt_wd;
      cnt_rd_ff <= cnt_mem[cnt_a];
   end

   always_comb begin
      key_we = 1'b0;
      key_wa = free_ff;
      cnt_we = 1'b0;
      cnt_a = hit_ok_ff ? hit_ff : free_ff;
      cnt_wd = {cnt_rd_ff[63:32] + 32'd1, cnt_rd_ff[31:0] + 32'(req_ff.packet_length)};
      if (state_ff == S_DONE && !req_ff.action && !hit_ok_ff && free_ok_ff) begin
         key_we = 1'b1;
         cnt_we = 1'b1;
         cnt_wd = {32'd1, 32'(req_ff.packet_length)};
      end
      if (state_ff == S_CWAIT) cnt_we = 1'b1;
      if (req_ff.action) cnt_a = first_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_chan.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_chan.valid && req_chan.ready) begin
                  req_ff <= req_chan.data;
                  key_ff <= req_key;
                  idx_ff <= '0;
                  pend_ff <= 1'b0;
                  hit_ok_ff <= 1'b0;
                  free_ok_ff <= 1'b0;
                  first_ok_ff <= 1'b0;
                  more_ff <= 1'b0;
                  hit_ff <= '0;
                  free_ff <= '0;
                  first_ff <= '0;
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (pend_ff) begin
                  if (valid_ff[prev_idx]) begin
                     if (first_ok_ff) more_ff <= 1'b1;
                     else begin
                        first_ok_ff <= 1'b1;
                        first_ff <= prev_idx;
                     end
                     if (!hit_ok_ff && key_rd_ff == key_ff) begin
                        hit_ok_ff <= 1'b1;
                        hit_ff <= prev_idx;
                     end
                  end else if (!free_ok_ff) begin
                     free_ok_ff <= 1'b1;
                     free_ff <= prev_idx;
                  end
               end
               if (idx_ff == CW'(TABLE_ENTRIES)) begin
                  pend_ff <= 1'b0;
                  state_ff <= S_DONE;
               end else begin
                  pend_ff <= 1'b1;
                  idx_ff <= idx_ff + CW'(1);
               end
            end
            S_DONE: begin
               if (req_ff.action) begin
                  if (first_ok_ff) begin
                     valid_ff[first_ff] <= 1'b0;
                     state_ff <= S_CRD;
                  end else begin
                     rsp_ff <= {STATUS_EMPTY, KEY_WIDTH'(0), 64'd0, 1'b1};
                     rsp_valid_ff <= 1'b1;
                     state_ff <= S_IDLE;
                  end
               end else if (hit_ok_ff) begin
                  state_ff <= S_CRD;
               end else if (free_ok_ff) begin
                  valid_ff[free_ff] <= 1'b1;
                  rsp_ff <= {STATUS_NEW, key_ff, 32'd1, 32'(req_ff.packet_length), 1'b0};
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  rsp_ff <= {STATUS_FULL, key_ff, 64'd0, 1'b0};
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            S_CRD: begin
               // counter read issued in the previous cycle
               if (req_ff.action) begin
                  state_ff <= S_OUT;
               end else state_ff <= S_CWAIT;
            end
            S_CWAIT: begin
               rsp_ff <= {STATUS_UPDATED, key_ff, cnt_wd, 1'b0};
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            S_OUT: begin
               rsp_ff <= {STATUS_DRAINED, key_rd_ff, cnt_rd_ff, !more_ff};
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // drain needs the stored key of first_ff: re-read it during S_DONE/S_CRD
   // by pointing the key read address there once the scan has finished.
endmodule
